>>> rtl/pts_pkg.sv
// Shared types, codes and constants for the PWM tone sequencer.
// Used by every module under rtl; depends on nothing.
package pts_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int HZ_W       = 16;
    localparam int DUR_W      = 16;
    localparam int CLOCK_W    = 32;
    localparam int DUTY_W     = 9;
    localparam int ICOUNT_W   = 7;
    localparam int PERIOD_W   = 17;
    localparam int RELOAD_W   = 16;
    localparam int COMPARE_W  = 17;
    localparam int ACTUAL_W   = 31;
    localparam int INDEX_W    = 6;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ICOUNT  = 3'd4;

    localparam logic [CLOCK_W-1:0]  CLOCK_RST = 32'd1000000;
    localparam logic [DUTY_W-1:0]   DUTY_RST  = 9'd128;
    localparam logic [DUTY_W-1:0]   DUTY_FULL = 9'd256;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 17'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 17'd65536;

    typedef struct packed {
        logic             muted;
        logic [DUR_W-1:0] duration;
        logic [HZ_W-1:0]  hz;
    } note_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> rtl/pts_note_mem.sv
// Note table storage: one write port, one registered read port.
// Depends on pts_pkg for the note entry type.
module pts_note_mem #(
    parameter int DEPTH = pts_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  pts_pkg::note_t  wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output pts_pkg::note_t  rdata
);
    import pts_pkg::*;

    note_t mem [DEPTH];
    note_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pts_divider.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 17-bit divisor.
// Depends on pts_pkg for widths and the status struct.
module pts_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pts_pkg::CLOCK_W-1:0]   dividend,
    input  logic [pts_pkg::PERIOD_W-1:0]  divisor,
    output logic [pts_pkg::CLOCK_W-1:0]   quotient,
    output pts_pkg::div_status_t          status
);
    import pts_pkg::*;

    localparam int CNT_W = $clog2(CLOCK_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLOCK_W - 1);

    logic [CLOCK_W-1:0]  quo_reg, quo_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] dsr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg, done_reg;
    logic [PERIOD_W:0]   shifted;
    logic [PERIOD_W:0]   trial;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[CLOCK_W-1]};
        trial   = shifted - {1'b0, dsr_reg};
        if (!trial[PERIOD_W])
        begin
            rem_next = trial[PERIOD_W-1:0];
            quo_next = {quo_reg[CLOCK_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[PERIOD_W-1:0];
            quo_next = {quo_reg[CLOCK_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/pwm_tone_sequencer.sv
// Top level: config registers, note sequencer and output word register.
// Depends on pts_pkg, pts_note_mem and pts_divider.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready    | mode, entry_index, entry_hz,
//          |           |                        | entry_duration, entry_muted
//  out     | out       | out_valid / out_ready  | pwm_on, apply_settings, reload_value,
//          |           |                        | compare_value, actual_hz,
//          |           |                        | sequence_finished, note_index
//
// A write, restart, silent tick or unused mode goes from S_IDLE to S_DONE and then to its output word.
// A tick passes through S_EVAL and S_DONE, and through S_DIV1 and S_DIV2 as well when a new period is
// computed: two passes of the shared divider (clock / frequency, then clock / period).
// in_ready is low while a word is in work; a finished word waits in S_DONE while the output word
// before it is still unaccepted. Reset clears all control state; no clearing pass is needed.
module pwm_tone_sequencer #(
    parameter int TABLE_DEPTH = pts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pts_pkg::MODE_W-1:0]        mode,
    input  logic [pts_pkg::INDEX_W-1:0]       entry_index,
    input  logic [pts_pkg::HZ_W-1:0]          entry_hz,
    input  logic [pts_pkg::DUR_W-1:0]         entry_duration,
    input  logic                              entry_muted,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              pwm_on,
    output logic                              apply_settings,
    output logic [pts_pkg::RELOAD_W-1:0]      reload_value,
    output logic [pts_pkg::COMPARE_W-1:0]     compare_value,
    output logic [pts_pkg::ACTUAL_W-1:0]      actual_hz,
    output logic                              sequence_finished,
    output logic [pts_pkg::INDEX_W-1:0]       note_index
);
    import pts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = (AW + 1 > ICOUNT_W) ? AW + 1 : ICOUNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIV1 = 5'b00100,
        S_DIV2 = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg;

    logic [CLOCK_W-1:0]  clock_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic                loop_reg;
    logic                silent_reg;
    logic [ICOUNT_W-1:0] icount_reg;

    logic [AW-1:0]       position_reg;
    logic [DUR_W-1:0]    tick_reg;
    logic                finished_reg;
    logic                running_reg;
    logic [HZ_W-1:0]     req_hz_reg;
    logic [ACTUAL_W-1:0] achieved_reg;

    logic                applied_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [RELOAD_W-1:0] reload_reg;
    logic [COMPARE_W-1:0] compare_reg;

    logic                 out_valid_reg;
    logic                 o_pwm_reg;
    logic                 o_apply_reg;
    logic [RELOAD_W-1:0]  o_reload_reg;
    logic [COMPARE_W-1:0] o_compare_reg;
    logic [ACTUAL_W-1:0]  o_actual_reg;
    logic                 o_finished_reg;
    logic [INDEX_W-1:0]   o_index_reg;

    logic                in_fire;
    logic                entry_in_range;
    logic                mem_we;
    note_t               wr_note;
    note_t               rd_note;

    logic                div_start;
    logic [PERIOD_W-1:0] div_divisor;
    logic [CLOCK_W-1:0]  div_quot;
    div_status_t         div_status;

    logic [CW-1:0]       count_eff;
    logic [CW-1:0]       pos_plus;
    logic [DUR_W-1:0]    limit;
    logic [DUR_W-1:0]    tick_inc;
    logic                note_end;
    logic [PERIOD_W-1:0] period_clamp;
    logic [DUTY_W-1:0]   duty_eff;
    logic [PERIOD_W+DUTY_W-1:0] product;
    logic                out_load;
    logic                eval_launch;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;

    assign entry_in_range = (CW'(entry_index) < DEPTH_C);
    assign mem_we         = in_fire && (mode == MODE_WRITE) && entry_in_range;
    assign wr_note        = '{muted: entry_muted, duration: entry_duration, hz: entry_hz};

    pts_note_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(entry_index)),
        .wdata (wr_note),
        .re    (in_fire),
        .raddr (position_reg),
        .rdata (rd_note)
    );

    assign count_eff = (CW'(icount_reg) > DEPTH_C) ? DEPTH_C : CW'(icount_reg);
    assign pos_plus  = CW'(position_reg) + 1'b1;
    assign limit     = (rd_note.duration == '0) ? DUR_W'(1) : rd_note.duration;
    assign tick_inc  = tick_reg + 1'b1;
    assign note_end  = (tick_inc >= limit);

    always_comb
    begin
        if (div_quot < CLOCK_W'(PERIOD_MIN))
        begin
            period_clamp = PERIOD_MIN;
        end
        else if (div_quot > CLOCK_W'(PERIOD_MAX))
        begin
            period_clamp = PERIOD_MAX;
        end
        else
        begin
            period_clamp = div_quot[PERIOD_W-1:0];
        end
    end

    assign duty_eff = (duty_reg > DUTY_FULL) ? DUTY_FULL : duty_reg;
    assign product  = period_reg * duty_eff;

    assign eval_launch = (state_reg == S_EVAL) && (count_eff != '0) && !finished_reg
                         && !rd_note.muted && (rd_note.hz != '0)
                         && !(running_reg && (req_hz_reg == rd_note.hz))
                         && (clock_reg != '0);

    assign div_start   = eval_launch || ((state_reg == S_DIV1) && div_status.done);
    assign div_divisor = (state_reg == S_EVAL) ? PERIOD_W'(rd_note.hz) : period_clamp;

    pts_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clock_reg),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg  <= CLOCK_RST;
            duty_reg   <= DUTY_RST;
            loop_reg   <= 1'b0;
            silent_reg <= 1'b0;
            icount_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CLOCK:  clock_reg  <= cfg_data;
                CFG_DUTY:   duty_reg   <= cfg_data[DUTY_W-1:0];
                CFG_LOOP:   loop_reg   <= cfg_data[0];
                CFG_SILENT: silent_reg <= cfg_data[0];
                CFG_ICOUNT: icount_reg <= cfg_data[ICOUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            position_reg <= '0;
            tick_reg     <= '0;
            finished_reg <= 1'b0;
            running_reg  <= 1'b0;
            req_hz_reg   <= '0;
            achieved_reg <= '0;
            applied_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        applied_reg <= 1'b0;
                        if (mode == MODE_RESTART)
                        begin
                            position_reg <= '0;
                            tick_reg     <= '0;
                            finished_reg <= 1'b0;
                            state_reg    <= S_DONE;
                        end
                        else if (mode == MODE_TICK && !silent_reg)
                        begin
                            state_reg <= S_EVAL;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_EVAL:
                begin
                    state_reg <= S_DONE;
                    if (count_eff == '0 || finished_reg)
                    begin
                        req_hz_reg   <= '0;
                        achieved_reg <= '0;
                        running_reg  <= 1'b0;
                    end
                    else
                    begin
                        if (note_end)
                        begin
                            tick_reg <= '0;
                            if (pos_plus >= count_eff)
                            begin
                                if (loop_reg)
                                begin
                                    position_reg <= '0;
                                end
                                else
                                begin
                                    finished_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                position_reg <= pos_plus[AW-1:0];
                            end
                        end
                        else
                        begin
                            tick_reg <= tick_inc;
                        end
                        if (rd_note.muted || rd_note.hz == '0)
                        begin
                            req_hz_reg   <= '0;
                            achieved_reg <= '0;
                            running_reg  <= 1'b0;
                        end
                        else if (!(running_reg && req_hz_reg == rd_note.hz))
                        begin
                            req_hz_reg <= rd_note.hz;
                            if (eval_launch)
                            begin
                                state_reg <= S_DIV1;
                            end
                        end
                    end
                end
                S_DIV1:
                begin
                    if (div_status.done)
                    begin
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (div_status.done)
                    begin
                        achieved_reg <= div_quot[ACTUAL_W-1:0];
                        applied_reg  <= 1'b1;
                        if (!running_reg && div_quot != '0)
                        begin
                            running_reg <= 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV1 && div_status.done)
        begin
            period_reg <= period_clamp;
        end
        if (state_reg == S_DIV2 && div_status.done)
        begin
            reload_reg  <= RELOAD_W'(period_reg - 1'b1);
            compare_reg <= product[COMPARE_W+7:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_pwm_reg      <= running_reg;
            o_apply_reg    <= applied_reg;
            o_reload_reg   <= applied_reg ? reload_reg : '0;
            o_compare_reg  <= applied_reg ? compare_reg : '0;
            o_actual_reg   <= achieved_reg;
            o_finished_reg <= finished_reg;
            o_index_reg    <= INDEX_W'(position_reg);
        end
    end

    assign out_valid         = out_valid_reg;
    assign pwm_on            = o_pwm_reg;
    assign apply_settings    = o_apply_reg;
    assign reload_value      = o_reload_reg;
    assign compare_value     = o_compare_reg;
    assign actual_hz         = o_actual_reg;
    assign sequence_finished = o_finished_reg;
    assign note_index        = o_index_reg;

    a_div_in_div_states: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("divider busy outside a divide state");

    a_no_settings_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !apply_settings) |-> (reload_value == '0 && compare_value == '0))
        else $error("reload or compare nonzero without new settings");

    a_compare_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && apply_settings) |-> (COMPARE_W'(reload_value) + 1'b1 >= compare_value))
        else $error("compare beyond period");

    a_off_means_zero_hz: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pwm_on) |-> (actual_hz == '0))
        else $error("achieved frequency nonzero while PWM is off");

endmodule
